>>> design/ppc_pkg.sv
package ppc_pkg;

  localparam int COORD_W = 32;
  // |a*x|/2^16 <= 2^46, three of them plus d stay below 2^48
  localparam int DIST_W  = 50;
  localparam int MAG_W   = 50;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CFG_IDX_W = 2;

  typedef logic [2:0][COORD_W-1:0] vert_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_A = 2'd0,
    CFG_PLANE_B = 2'd1,
    CFG_PLANE_C = 2'd2,
    CFG_PLANE_D = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                start;
    logic [MAG_W-1:0]    rem;
    logic [COORD_W-1:0]  lo;
    logic [MAG_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [COORD_W-1:0] vsel(vert_t v, logic [1:0] idx);
    logic [COORD_W-1:0] r;
    unique case (idx)
      2'd0:    r = v[0];
      2'd1:    r = v[1];
      2'd2:    r = v[2];
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sat_coord(logic signed [COORD_W+1:0] v);
    logic [COORD_W-1:0] r;
    if (v > $signed({3'b000, {(COORD_W-1){1'b1}}})) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < $signed({3'b111, {(COORD_W-1){1'b0}}})) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/ppc_if.sv
interface ppc_in_if import ppc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [COORD_W-1:0] in_z;
  logic               in_final;

  modport source (output valid, in_x, in_y, in_z, in_final, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_final, output ready);
endinterface

interface ppc_out_if import ppc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [COORD_W-1:0] out_z;
  logic               out_final;
  logic               out_empty;

  modport source (output valid, out_x, out_y, out_z, out_final, out_empty, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_final, out_empty, output ready);
endinterface

>>> design/ppc_mul.sv
module ppc_mul import ppc_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> design/ppc_div.sv
module ppc_div import ppc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [4:0]         cnt_q;
  logic [MAG_W-1:0]   rem_q;
  logic [MAG_W-1:0]   den_q;
  logic [COORD_W-1:0] lo_q;
  logic [COORD_W-1:0] quot_q;
  logic [MAG_W:0]     shifted;
  logic [MAG_W:0]     trial;

  assign shifted = {rem_q, lo_q[COORD_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle; remainder stays below the divisor
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      den_q <= req_i.den;
      lo_q  <= req_i.lo;
    end else if (busy_q) begin
      lo_q <= {lo_q[COORD_W-2:0], 1'b0};
      if (!trial[MAG_W]) begin
        rem_q  <= trial[MAG_W-1:0];
        quot_q <= {quot_q[COORD_W-2:0], 1'b1};
      end else begin
        rem_q  <= shifted[MAG_W-1:0];
        quot_q <= {quot_q[COORD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

>>> design/polygon_plane_clipper_core.sv
// Channel   Dir  Beat payload                          Handshake
// in_i      in   in_x, in_y, in_z, in_final            valid/ready
// out_o     out  out_x, out_y, out_z, out_final,       valid/ready
//                out_empty
// cfg       in   cfg_idx_i, cfg_data_i                 cfg_we_i, no wait
//
// Each vertex runs a distance pass; each crossing point adds, for every
// coordinate, a pass through the multiplier and a run of the divider (up to two
// crossings on the final vertex), and the divider is a 32-step shared unit;
// one shared 33x33 multiplier computes distances and the
// crossing numerators. Reset clears the plane to zero and drops any polygon
// in progress. in_i.ready is high only while idle; a stalled output holds
// the sequencer only when a new beat must go out.
module polygon_plane_clipper_core import ppc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ppc_in_if.sink               in_i,
  ppc_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DIST  = 12'b000000000010,
    S_ENTER = 12'b000000000100,
    S_EDGE  = 12'b000000001000,
    S_XMUL0 = 12'b000000010000,
    S_XMUL1 = 12'b000000100000,
    S_XDIV  = 12'b000001000000,
    S_XWAIT = 12'b000010000000,
    S_PUSHX = 12'b000100000000,
    S_PUSHP = 12'b001000000000,
    S_NEXT  = 12'b010000000000,
    S_FLUSH = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // plane registers
  logic [3:0][COORD_W-1:0] plane_q;

  // current vertex and its distance
  vert_t                     cur_q;
  logic                      fin_q;
  logic signed [DIST_W-1:0]  fc_q;
  logic [1:0]                cnt_q;

  // polygon state
  vert_t                     first_q, prev_q;
  logic signed [DIST_W-1:0]  ffirst_q, pd_q;
  logic                      have_first_q;
  logic                      phase_q;

  // edge operands s -> p
  vert_t                     s_q, p_q;
  logic signed [DIST_W-1:0]  fs_q, fp_q;
  logic                      pin_q, sgn_q;
  logic [MAG_W-1:0]          nfs_mag_q, den_mag_q;
  logic [1:0]                k_q;
  logic [63:0]               p0_q;
  vert_t                     xres_q;

  // held-back output vertex, so the last beat can carry out_final
  vert_t                     held_q;
  logic                      held_v_q;

  // output register
  logic                      out_valid_q;
  vert_t                     out_v_q;
  logic                      out_fin_q, out_empty_q;

  // shared units
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  ppc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ppc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --- edge classification ---
  logic                      fs_le, fp_le;
  logic signed [DIST_W:0]    den;
  logic [DIST_W:0]           den_neg;
  logic [DIST_W-1:0]         fs_neg;

  assign fs_le   = fs_q[DIST_W-1] | (fs_q == '0);
  assign fp_le   = fp_q[DIST_W-1] | (fp_q == '0);
  assign den     = {fp_q[DIST_W-1], fp_q} - {fs_q[DIST_W-1], fs_q};
  assign den_neg = -den;
  assign fs_neg  = -fs_q;

  // --- per-coordinate crossing terms ---
  logic [COORD_W-1:0]        s_k, p_k;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          diff_neg;
  logic [COORD_W-1:0]        dmag;
  logic                      xneg;
  logic signed [COORD_W+1:0] xsum;
  logic [MAG_W-1:0]          num_hi;

  assign s_k      = vsel(s_q, k_q);
  assign p_k      = vsel(p_q, k_q);
  assign diff     = $signed({p_k[COORD_W-1], p_k}) - $signed({s_k[COORD_W-1], s_k});
  assign diff_neg = -diff;
  assign dmag     = diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
  assign xneg     = diff[COORD_W] ^ sgn_q;
  assign xsum     = xneg
      ? $signed({{2{s_k[COORD_W-1]}}, s_k}) - $signed({2'b00, div_rsp.quot})
      : $signed({{2{s_k[COORD_W-1]}}, s_k}) + $signed({2'b00, div_rsp.quot});
  // quotient stays below 2^32, so the upper numerator part is below the divisor
  assign num_hi   = MAG_W'({32'd0, p0_q[63:32]} + mul_p[63:0]);

  // coordinate of the current vertex that the distance pass multiplies now
  logic [COORD_W-1:0]        cur_k;

  assign cur_k = vsel(cur_q, cnt_q);

  // --- multiplier operand select ---
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DIST: begin
        mul_a = $signed({plane_q[cnt_q][COORD_W-1], plane_q[cnt_q]});
        mul_b = $signed({cur_k[COORD_W-1], cur_k});
      end
      S_XMUL0: begin
        mul_a = $signed({1'b0, dmag});
        mul_b = $signed({1'b0, nfs_mag_q[COORD_W-1:0]});
      end
      S_XMUL1: begin
        mul_a = $signed({1'b0, dmag});
        mul_b = $signed({{(MUL_W-MAG_W+COORD_W){1'b0}}, nfs_mag_q[MAG_W-1:COORD_W]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_req.start = (state_q == S_XDIV);
  assign div_req.rem   = num_hi;
  assign div_req.lo    = p0_q[COORD_W-1:0];
  assign div_req.den   = den_mag_q;

  // --- push and output load ---
  logic  out_free, push_ok, out_load;
  vert_t push_item;
  vert_t load_v;
  logic  load_fin, load_empty;

  assign out_free  = !out_valid_q || out_o.ready;
  assign push_ok   = !held_v_q || out_free;
  assign push_item = (state_q == S_PUSHX) ? xres_q : p_q;

  always_comb begin
    out_load   = 1'b0;
    load_v     = held_q;
    load_fin   = 1'b0;
    load_empty = 1'b0;
    unique case (state_q)
      S_PUSHX, S_PUSHP: begin
        out_load = held_v_q && out_free;
      end
      S_FLUSH: begin
        out_load   = out_free;
        load_v     = held_v_q ? held_q : '0;
        load_fin   = 1'b1;
        load_empty = !held_v_q;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // --- sequencer ---
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_DIST;
      S_DIST:  if (cnt_q == 2'd3) state_d = S_ENTER;
      S_ENTER: state_d = have_first_q ? S_EDGE : S_NEXT;
      S_EDGE: begin
        if (fs_le != fp_le) begin
          state_d = S_XMUL0;
        end else if (fp_le) begin
          state_d = S_PUSHP;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_XMUL0: state_d = S_XMUL1;
      S_XMUL1: state_d = S_XDIV;
      S_XDIV:  state_d = S_XWAIT;
      S_XWAIT: begin
        if (div_rsp.done) state_d = (k_q == 2'd2) ? S_PUSHX : S_XMUL0;
      end
      S_PUSHX: if (push_ok) state_d = pin_q ? S_PUSHP : S_NEXT;
      S_PUSHP: if (push_ok) state_d = S_NEXT;
      S_NEXT: begin
        if (phase_q) begin
          state_d = S_FLUSH;
        end else begin
          state_d = fin_q ? S_EDGE : S_IDLE;
        end
      end
      S_FLUSH: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      plane_q      <= '0;
      have_first_q <= 1'b0;
      held_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      k_q          <= '0;
      phase_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PLANE_A: plane_q[CFG_PLANE_A] <= cfg_data_i;
          CFG_PLANE_B: plane_q[CFG_PLANE_B] <= cfg_data_i;
          CFG_PLANE_C: plane_q[CFG_PLANE_C] <= cfg_data_i;
          CFG_PLANE_D: plane_q[CFG_PLANE_D] <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          cnt_q   <= '0;
          phase_q <= 1'b0;
        end
        S_DIST:  cnt_q <= cnt_q + 2'd1;
        S_ENTER: have_first_q <= 1'b1;
        S_EDGE:  k_q <= '0;
        S_XWAIT: if (div_rsp.done) k_q <= k_q + 2'd1;
        S_PUSHX, S_PUSHP: if (push_ok) held_v_q <= 1'b1;
        S_NEXT:  if (!phase_q && fin_q) phase_q <= 1'b1;
        S_FLUSH: begin
          if (out_free) begin
            have_first_q <= 1'b0;
            held_v_q     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_v_q     <= load_v;
      out_fin_q   <= load_fin;
      out_empty_q <= load_empty;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cur_q <= {in_i.in_z, in_i.in_y, in_i.in_x};
          fin_q <= in_i.in_final;
          fc_q  <= DIST_W'($signed(plane_q[CFG_PLANE_D]));
        end
      end
      S_DIST: begin
        // accumulate the floored product issued last cycle
        if (cnt_q != 2'd0) fc_q <= fc_q + mul_p[DIST_W+15:16];
      end
      S_ENTER: begin
        if (have_first_q) begin
          s_q  <= prev_q;
          fs_q <= pd_q;
          p_q  <= cur_q;
          fp_q <= fc_q;
        end else begin
          first_q  <= cur_q;
          ffirst_q <= fc_q;
        end
      end
      S_EDGE: begin
        pin_q     <= fp_le;
        nfs_mag_q <= fs_q[DIST_W-1] ? fs_neg : fs_q;
        den_mag_q <= den[DIST_W] ? den_neg[MAG_W-1:0] : den[MAG_W-1:0];
        sgn_q     <= (!fs_le) ^ den[DIST_W];
      end
      S_XMUL1: p0_q <= mul_p[63:0];
      S_XWAIT: begin
        if (div_rsp.done) begin
          unique case (k_q)
            2'd0:    xres_q[0] <= sat_coord(xsum);
            2'd1:    xres_q[1] <= sat_coord(xsum);
            default: xres_q[2] <= sat_coord(xsum);
          endcase
        end
      end
      S_PUSHX, S_PUSHP: if (push_ok) held_q <= push_item;
      S_NEXT: begin
        if (!phase_q) begin
          prev_q <= cur_q;
          pd_q   <= fc_q;
          // closing edge: last vertex back to the first
          s_q    <= cur_q;
          fs_q   <= fc_q;
          p_q    <= first_q;
          fp_q   <= ffirst_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_x     = out_v_q[0];
  assign out_o.out_y     = out_v_q[1];
  assign out_o.out_z     = out_v_q[2];
  assign out_o.out_final = out_fin_q;
  assign out_o.out_empty = out_empty_q;

  // accepted beat always starts the distance pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_DIST))
    else $error("accepted vertex did not start distance pass");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_XWAIT))
    else $error("divider result with no waiting crossing");

  // never overwrite an output beat that was not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("output beat overwritten");

endmodule

>>> tb/tb_polygon_plane_clipper_core.sv
module tb_polygon_plane_clipper_core;
  import ppc_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        fin;
    logic        empty;
  } clip_vert_t;

  // Scoreboard: tracks the clipper state and the queue of vertices still due.
  class clip_scoreboard;
    longint pa, pb, pc, pd;
    longint first_v[3], prev_v[3], held_v[3];
    longint first_dist, prev_dist;
    bit     in_poly, holding;
    clip_vert_t due_q[$];
    int     errors;
    int     n_checked;

    function new();
      pa = 0; pb = 0; pc = 0; pd = 0;
      in_poly = 0; holding = 0; errors = 0; n_checked = 0;
      first_dist = 0; prev_dist = 0;
      for (int k = 0; k < 3; k++) begin
        first_v[k] = 0; prev_v[k] = 0; held_v[k] = 0;
      end
    endfunction

    function void set_plane(cfg_idx_e idx, logic [31:0] val);
      longint v;
      v = longint'($signed(val));
      case (idx)
        CFG_PLANE_A: pa = v;
        CFG_PLANE_B: pb = v;
        CFG_PLANE_C: pc = v;
        CFG_PLANE_D: pd = v;
      endcase
    endfunction

    // Floor of a Q32.32 product down to Q16.16 (arithmetic shift floors).
    function longint plane_dist(longint v[3]);
      return ((pa * v[0]) >>> 16) + ((pb * v[1]) >>> 16) + ((pc * v[2]) >>> 16) + pd;
    endfunction

    function void add_cross(longint s[3], longint fs, longint p[3], longint fp,
                            ref longint lst[$]);
      logic signed [129:0] num, q;
      logic signed [129:0] den;
      longint r;
      den = fp - fs;
      for (int k = 0; k < 3; k++) begin
        num = (p[k] - s[k]);
        num = num * (-fs);
        q = num / den;  // truncates toward zero
        r = s[k] + longint'(q);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        lst.push_back(r);
      end
    endfunction

    function void do_edge(longint s[3], longint fs, longint p[3], longint fp,
                          ref longint lst[$]);
      bit pin, sin;
      pin = fp <= 0;
      sin = fs <= 0;
      if (pin != sin) add_cross(s, fs, p, fp, lst);
      if (pin) for (int k = 0; k < 3; k++) lst.push_back(p[k]);
    endfunction

    function void push_due(longint x, longint y, longint z, bit fin, bit empty);
      clip_vert_t e;
      e.x = x[31:0]; e.y = y[31:0]; e.z = z[31:0]; e.fin = fin; e.empty = empty;
      due_q.push_back(e);
    endfunction

    function void note_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
      longint cur[3];
      longint fc;
      longint lst[$];
      int n0;
      cur[0] = longint'($signed(x));
      cur[1] = longint'($signed(y));
      cur[2] = longint'($signed(z));
      fc = plane_dist(cur);
      if (in_poly) do_edge(prev_v, prev_dist, cur, fc, lst);
      else begin
        first_v = cur;
        first_dist = fc;
      end
      prev_v = cur;
      prev_dist = fc;
      in_poly = 1;
      if (!fin) begin
        for (int i = 0; i < lst.size(); i += 3) begin
          if (holding) push_due(held_v[0], held_v[1], held_v[2], 0, 0);
          held_v[0] = lst[i]; held_v[1] = lst[i+1]; held_v[2] = lst[i+2];
          holding = 1;
        end
        return;
      end
      do_edge(cur, fc, first_v, first_dist, lst);
      n0 = due_q.size();
      if (holding) push_due(held_v[0], held_v[1], held_v[2], 0, 0);
      for (int i = 0; i < lst.size(); i += 3) push_due(lst[i], lst[i+1], lst[i+2], 0, 0);
      if (due_q.size() == n0) push_due(0, 0, 0, 1, 1);
      else due_q[$].fin = 1;
      in_poly = 0;
      holding = 0;
    endfunction

    function void check_result(clip_vert_t got);
      clip_vert_t e;
      n_checked++;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected beat x=%h y=%h z=%h fin=%b empty=%b", $time,
                 got.x, got.y, got.z, got.fin, got.empty);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (got.x !== e.x) begin
        $display("%0t: out_x expected %h actual %h", $time, e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $display("%0t: out_y expected %h actual %h", $time, e.y, got.y); errors++;
      end
      if (got.z !== e.z) begin
        $display("%0t: out_z expected %h actual %h", $time, e.z, got.z); errors++;
      end
      if (got.fin !== e.fin) begin
        $display("%0t: out_final expected %b actual %b", $time, e.fin, got.fin); errors++;
      end
      if (got.empty !== e.empty) begin
        $display("%0t: out_empty expected %b actual %b", $time, e.empty, got.empty);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COORD_W-1:0] cfg_data_i;

  ppc_in_if  vin();
  ppc_out_if vout();

  polygon_plane_clipper_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (vin.sink),
    .out_o      (vout.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  clip_scoreboard sb;
  int  cycle_cnt;
  int  n_vertices;
  int  n_polys;
  bit  hold_off_req;  // ask the output side for a long stall

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // Timeout: allows for the worst-case work per vertex, random gaps on both
  // sides and stalled beats; take a wide margin.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 600000) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_polygon_plane_clipper_core failed");
      $finish;
    end
  end

  // Result side: sample at the rising edge, change ready at the falling edge.
  initial begin : out_side
    int gap;
    clip_vert_t got;
    vout.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        // long stall so the core fills up and drops in_i.ready
        vout.ready <= 1'b0;
        repeat (600) @(negedge clk_i);
        hold_off_req = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        vout.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      vout.ready <= 1'b1;
      do @(posedge clk_i); while (!vout.valid);
      got.x = vout.out_x; got.y = vout.out_y; got.z = vout.out_z;
      got.fin = vout.out_final; got.empty = vout.out_empty;
      sb.check_result(got);
    end
  end

  // valid stays up after the accepting edge; the core leaves idle at that
  // edge, and the next call or drain() replaces or drops it.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin,
                             bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vin.valid    <= 1'b1;
    vin.in_x     <= x;
    vin.in_y     <= y;
    vin.in_z     <= z;
    vin.in_final <= fin;
    do @(posedge clk_i); while (!vin.ready);
    sb.note_vertex(x, y, z, fin);
    n_vertices++;
    if (fin) n_polys++;
    @(negedge clk_i);
  endtask

  // Drain: wait for every due vertex, then wait out a clip-only vertex
  // still in flight before touching the plane.
  task automatic drain();
    int guard;
    guard = 0;
    vin.valid <= 1'b0;
    while (sb.due_q.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_plane(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_plane(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_plane4(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d);
    write_plane(CFG_PLANE_A, a);
    write_plane(CFG_PLANE_B, b);
    write_plane(CFG_PLANE_C, c);
    write_plane(CFG_PLANE_D, d);
  endtask

  // Random coordinate: mostly moderate, sometimes extreme or fully random.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    endcase
  endfunction

  function automatic logic [31:0] rand_plane_coef();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      2:       return 32'h0;
      default: return $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000;
    endcase
  endfunction

  task automatic send_polygon(int nv);
    for (int i = 0; i < nv; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), i == nv - 1);
  endtask

  initial begin : stim
    sb = new();
    cycle_cnt = 0;
    n_vertices = 0;
    n_polys = 0;
    hold_off_req = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PLANE_A;
    cfg_data_i = '0;
    vin.valid = 1'b0;
    vin.in_x = '0;
    vin.in_y = '0;
    vin.in_z = '0;
    vin.in_final = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero plane puts every vertex inside (D = 0).
    send_vertex(32'h7fffffff, 32'h80000000, 32'h0, 1);  // single vertex, kept
    send_vertex(32'h00010000, 32'h0, 32'h0, 0);
    send_vertex(32'hffffffff, 32'h7fffffff, 32'h80000000, 0);
    send_vertex(32'h0, 32'h00020000, 32'h00030000, 1);
    drain();

    // Plane x <= 1.0: triangle straddles it, then single vertex outside.
    set_plane4(32'h00010000, 32'h0, 32'h0, 32'hffff0000);
    send_vertex(32'h0, 32'h0, 32'h0, 0);
    send_vertex(32'h00030000, 32'h0, 32'h0, 0);
    send_vertex(32'h00030000, 32'h00020000, 32'h00010000, 1);
    send_vertex(32'h00050000, 32'h0, 32'h0, 1);  // fully clipped single vertex
    send_vertex(32'h00050000, 32'h0, 32'h0, 0);  // fully clipped triangle
    send_vertex(32'h00060000, 32'h1, 32'h0, 0);
    send_vertex(32'h00070000, 32'h0, 32'h1, 1);
    // polygon starting outside so the closing edge crosses
    send_vertex(32'h00040000, 32'h0, 32'h0, 0);
    send_vertex(32'hfffe0000, 32'h00010000, 32'h0, 0);
    send_vertex(32'hfffe0000, 32'hffff0000, 32'h0, 1);
    drain();

    // Extreme plane and coordinates to hit saturation and huge distances.
    set_plane4(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
    send_vertex(32'h80000000, 32'h80000000, 32'h7fffffff, 1);
    // Plane changed mid-polygon: stored distances keep the old plane.
    send_vertex(32'h00010000, 32'h00020000, 32'h0, 0);
    send_vertex(32'hffff0000, 32'h0, 32'h00010000, 0);
    drain();
    write_plane(CFG_PLANE_D, 32'h7fffffff);
    send_vertex(32'h00020000, 32'h00010000, 32'hffff0000, 1);
    drain();

    // Random phases with fresh planes. One phase stalls the output for a long
    // stretch while vertices keep coming.
    for (int ph = 0; ph < 8; ph++) begin
      set_plane4(rand_plane_coef(), rand_plane_coef(), rand_plane_coef(),
                 rand_plane_coef());
      if (ph == 3) hold_off_req = 1;
      while (n_vertices < 25 + (ph + 1) * 31) begin
        if ($urandom_range(0, 9) == 0)
          send_vertex($urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
        else
          send_polygon($urandom_range(1, 7));
      end
      // close any open polygon before the plane changes
      if (sb.in_poly) send_vertex(rand_coord(), rand_coord(), rand_coord(), 1);
      drain();
    end

    drain();
    $display("covered %0d vertices in %0d polygons, %0d result beats checked",
             n_vertices, n_polys, sb.n_checked);
    $display("plane extremes, empty and single-vertex polygons, mid-polygon plane write");
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("tb_polygon_plane_clipper_core passed");
    end else begin
      $display("%0d expected beats left over, %0d mismatches", sb.due_q.size(), sb.errors);
      $display("tb_polygon_plane_clipper_core failed");
    end
    $finish;
  end

endmodule

>>> polygon_plane_clipper_core.f
design/ppc_pkg.sv
design/ppc_if.sv
design/ppc_mul.sv
design/ppc_div.sv
design/polygon_plane_clipper_core.sv
tb/tb_polygon_plane_clipper_core.sv
